### src/assert_macros.svh
// Assertion macros shared by the RTL of the fixed-point ALU.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_AT(lbl, clk, rst, !(expr), msg)
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### src/fpa_pkg.sv
// Shared constants, command codes and pipeline side-band type for the ALU.
// No dependencies.
package fpa_pkg;

   localparam int unsigned DATA_W            = 32;
   localparam int unsigned CMD_W             = 4;
   localparam int unsigned FRAC_BITS_DEFAULT = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_MIN      = 4'd4,
      CMD_MAX      = 4'd5,
      CMD_INC      = 4'd6,
      CMD_TO_INT   = 4'd7,
      CMD_FROM_INT = 4'd8
   } cmd_type;

   // Everything that rides alongside the divider datapath
   typedef struct packed {
      logic [DATA_W-1:0] alt;     // result for every command but divide
      logic              lt;
      logic              eq;
      logic              gt;
      logic              is_div;
      logic              dz;
      logic              neg;     // quotient sign
   } side_type;

endpackage

### src/fpa_if.sv
// Request and response channel interfaces of the fixed-point ALU.
// Depends on fpa_pkg for field widths.
interface fpa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [fpa_pkg::CMD_W-1:0]      command;
   logic signed [fpa_pkg::DATA_W-1:0]     operand_a;
   logic signed [fpa_pkg::DATA_W-1:0]     operand_b;

   modport source (output valid, output command, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input command, input operand_a, input operand_b,
                   output ready);
endinterface

interface fpa_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fpa_pkg::DATA_W-1:0]     result;
   logic                                  a_less;
   logic                                  a_equal;
   logic                                  a_greater;
   logic                                  divide_by_zero;

   modport source (output valid, output result, output a_less, output a_equal,
                   output a_greater, output divide_by_zero, input ready);
   modport sink   (input valid, input result, input a_less, input a_equal,
                   input a_greater, input divide_by_zero, output ready);
endinterface

### src/fpa_front.sv
// Front end: input register, operation stage (multiplier, simple ops, compare,
// divider operands), select stage that shifts the product. Uses fpa_pkg.
module fpa_front #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
   localparam int unsigned DVD_W    = fpa_pkg::DATA_W + FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   fpa_req_if.sink                       req_bus,
   output logic                          valid_out,
   output fpa_pkg::side_type             side_out,
   output logic [DVD_W-1:0]              dvd_out,
   output logic [fpa_pkg::DATA_W-1:0]    dvsr_out
);

   localparam int unsigned W = fpa_pkg::DATA_W;

   // stage 1: input beat
   logic                    s1_valid_ff;
   logic [fpa_pkg::CMD_W-1:0] s1_cmd_ff;
   logic signed [W-1:0]     s1_a_ff, s1_b_ff;

   // stage 2: operations
   logic                    s2_valid_ff;
   logic                    s2_is_mul_ff;
   logic signed [2*W-1:0]   s2_prod_ff, s2_prod_in;
   logic [W-1:0]            s2_simple_ff, s2_simple_in;
   logic                    s2_lt_ff, s2_eq_ff, s2_gt_ff;
   logic                    s2_is_div_ff, s2_dz_ff, s2_neg_ff;
   logic [DVD_W-1:0]        s2_dvd_ff, s2_dvd_in;
   logic [W-1:0]            s2_dvsr_ff, s2_dvsr_in;

   // stage 3: select
   logic                    s3_valid_ff;
   fpa_pkg::side_type       s3_side_ff, s3_side_in;
   logic [DVD_W-1:0]        s3_dvd_ff;
   logic [W-1:0]            s3_dvsr_ff;

   logic                    lt_in, gt_in, eq_in;
   logic signed [W-1:0]     asr_a;
   logic [W-1:0]            abs_a;
   logic signed [2*W-1:0]   prod_shifted;

   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_bus.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff    <= req_bus.command;
         s1_a_ff      <= req_bus.operand_a;
         s1_b_ff      <= req_bus.operand_b;

         s2_is_mul_ff <= (s1_cmd_ff == fpa_pkg::CMD_MUL);
         s2_is_div_ff <= (s1_cmd_ff == fpa_pkg::CMD_DIV);
         s2_dz_ff     <= (s1_cmd_ff == fpa_pkg::CMD_DIV) && (s1_b_ff == '0);
         s2_neg_ff    <= s1_a_ff[W-1] ^ s1_b_ff[W-1];
         s2_prod_ff   <= s2_prod_in;
         s2_simple_ff <= s2_simple_in;
         s2_lt_ff     <= lt_in;
         s2_eq_ff     <= eq_in;
         s2_gt_ff     <= gt_in;
         s2_dvd_ff    <= s2_dvd_in;
         s2_dvsr_ff   <= s2_dvsr_in;

         s3_side_ff   <= s3_side_in;
         s3_dvd_ff    <= s2_dvd_ff;
         s3_dvsr_ff   <= s2_dvsr_ff;
      end
   end

   always_comb begin
      lt_in        = s1_a_ff < s1_b_ff;
      gt_in        = s1_a_ff > s1_b_ff;
      eq_in        = s1_a_ff == s1_b_ff;
      s2_prod_in   = s1_a_ff * s1_b_ff;
      asr_a        = s1_a_ff >>> FRAC_BITS;
      abs_a        = s1_a_ff[W-1] ? W'(-s1_a_ff) : W'(s1_a_ff);
      s2_dvd_in    = DVD_W'(abs_a) << FRAC_BITS;
      s2_dvsr_in   = s1_b_ff[W-1] ? W'(-s1_b_ff) : W'(s1_b_ff);
      case (s1_cmd_ff)
         fpa_pkg::CMD_ADD:      s2_simple_in = W'(s1_a_ff + s1_b_ff);
         fpa_pkg::CMD_SUB:      s2_simple_in = W'(s1_a_ff - s1_b_ff);
         fpa_pkg::CMD_MIN:      s2_simple_in = lt_in ? s1_a_ff : s1_b_ff;
         fpa_pkg::CMD_MAX:      s2_simple_in = gt_in ? s1_a_ff : s1_b_ff;
         fpa_pkg::CMD_INC:      s2_simple_in = W'(s1_a_ff + 1);
         fpa_pkg::CMD_TO_INT:   s2_simple_in = asr_a;
         fpa_pkg::CMD_FROM_INT: s2_simple_in = W'(s1_a_ff) << FRAC_BITS;
         default:               s2_simple_in = '0;
      endcase
   end

   always_comb begin
      prod_shifted      = s2_prod_ff >>> FRAC_BITS;
      s3_side_in.alt    = s2_is_mul_ff ? prod_shifted[W-1:0] : s2_simple_ff;
      s3_side_in.lt     = s2_lt_ff;
      s3_side_in.eq     = s2_eq_ff;
      s3_side_in.gt     = s2_gt_ff;
      s3_side_in.is_div = s2_is_div_ff;
      s3_side_in.dz     = s2_dz_ff;
      s3_side_in.neg    = s2_neg_ff;
   end

   assign valid_out = s3_valid_ff;
   assign side_out  = s3_side_ff;
   assign dvd_out   = s3_dvd_ff;
   assign dvsr_out  = s3_dvsr_ff;

endmodule

### src/fpa_div_step.sv
// One restoring-division step as a pipeline stage: one quotient bit per beat.
// Side-band results travel with the beat. Uses fpa_pkg.
module fpa_div_step #(
   parameter int unsigned DVD_W = fpa_pkg::DATA_W + fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          valid_in,
   input  fpa_pkg::side_type             side_in,
   input  logic [fpa_pkg::DATA_W-1:0]    rem_in,
   input  logic [DVD_W-1:0]              dq_in,
   input  logic [fpa_pkg::DATA_W-1:0]    dvsr_in,
   output logic                          valid_out,
   output fpa_pkg::side_type             side_out,
   output logic [fpa_pkg::DATA_W-1:0]    rem_out,
   output logic [DVD_W-1:0]              dq_out,
   output logic [fpa_pkg::DATA_W-1:0]    dvsr_out
);

   localparam int unsigned W = fpa_pkg::DATA_W;

   logic              valid_ff;
   fpa_pkg::side_type side_ff;
   logic [W-1:0]      rem_ff, rem_in_n;
   logic [DVD_W-1:0]  dq_ff, dq_in_n;
   logic [W-1:0]      dvsr_ff;
   logic [W:0]        rem_sh;
   logic [W+1:0]      diff;
   logic              ge;

   // dividend bits leave at the top of dq as quotient bits enter at the bottom
   always_comb begin
      rem_sh   = {rem_in, dq_in[DVD_W-1]};
      diff     = {1'b0, rem_sh} - {2'b00, dvsr_in};
      ge       = !diff[W+1];
      rem_in_n = ge ? diff[W-1:0] : rem_sh[W-1:0];
      dq_in_n  = {dq_in[DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         rem_ff  <= rem_in_n;
         dq_ff   <= dq_in_n;
         dvsr_ff <= dvsr_in;
      end
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign rem_out   = rem_ff;
   assign dq_out    = dq_ff;
   assign dvsr_out  = dvsr_ff;

endmodule

### src/fpa_back.sv
// Output stage: applies the quotient sign, picks the final result and holds the
// response beat until taken; produces the pipeline advance. Uses fpa_pkg, fpa_rsp_if.
module fpa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          valid_in,
   input  fpa_pkg::side_type             side_in,
   input  logic [fpa_pkg::DATA_W-1:0]    quot_in,
   output logic                          adv,
   fpa_rsp_if.source                     rsp_bus
);

   localparam int unsigned W = fpa_pkg::DATA_W;

   logic         valid_ff;
   logic [W-1:0] result_ff, result_in;
   logic         lt_ff, eq_ff, gt_ff, dz_ff;

   assign adv = !valid_ff || rsp_bus.ready;

   always_comb begin
      if (side_in.dz) begin
         result_in = '0;
      end else if (side_in.is_div) begin
         result_in = side_in.neg ? W'(-quot_in) : quot_in;
      end else begin
         result_in = side_in.alt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= result_in;
         lt_ff     <= side_in.lt;
         eq_ff     <= side_in.eq;
         gt_ff     <= side_in.gt;
         dz_ff     <= side_in.dz;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.result         = result_ff;
   assign rsp_bus.a_less         = lt_ff;
   assign rsp_bus.a_equal        = eq_ff;
   assign rsp_bus.a_greater      = gt_ff;
   assign rsp_bus.divide_by_zero = dz_ff;

endmodule

### src/fixed_point_alu.sv
// Fixed-point ALU, Q(31-FRAC_BITS).FRAC_BITS, fully pipelined.
// Throughput: one beat per cycle while the response is not stalled; the divider is
// 32 + FRAC_BITS restoring steps, one stage each, and every command flows through the
// same stages to keep order. A stalled response freezes the whole pipeline.
// Synchronous reset clears valid bits.
`include "assert_macros.svh"

module fixed_point_alu #(
   parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fpa_req_if.sink     req_bus,
   fpa_rsp_if.source   rsp_bus
);

   localparam int unsigned W     = fpa_pkg::DATA_W;
   localparam int unsigned DVD_W = W + FRAC_BITS;

   logic              adv;
   logic              valid_s [DVD_W+1];
   fpa_pkg::side_type side_s  [DVD_W+1];
   logic [W-1:0]      rem_s   [DVD_W+1];
   logic [DVD_W-1:0]  dq_s    [DVD_W+1];
   logic [W-1:0]      dvsr_s  [DVD_W+1];

   fpa_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_bus   (req_bus),
      .valid_out (valid_s[0]),
      .side_out  (side_s[0]),
      .dvd_out   (dq_s[0]),
      .dvsr_out  (dvsr_s[0])
   );

   assign rem_s[0] = '0;

   for (genvar i = 0; i < DVD_W; i++) begin : g_div
      fpa_div_step #(
         .DVD_W (DVD_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .valid_in  (valid_s[i]),
         .side_in   (side_s[i]),
         .rem_in    (rem_s[i]),
         .dq_in     (dq_s[i]),
         .dvsr_in   (dvsr_s[i]),
         .valid_out (valid_s[i+1]),
         .side_out  (side_s[i+1]),
         .rem_out   (rem_s[i+1]),
         .dq_out    (dq_s[i+1]),
         .dvsr_out  (dvsr_s[i+1])
      );
   end

   fpa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .valid_in (valid_s[DVD_W]),
      .side_in  (side_s[DVD_W]),
      .quot_in  (dq_s[DVD_W][W-1:0]),
      .adv      (adv),
      .rsp_bus  (rsp_bus)
   );

   `ASSERT_AT(a_dz_zero, clock, reset, (rsp_bus.valid && rsp_bus.divide_by_zero) |-> (rsp_bus.result == '0), "divide by zero beat with nonzero result")
   `ASSERT_AT(a_cmp_onehot, clock, reset, rsp_bus.valid |-> $onehot({rsp_bus.a_less, rsp_bus.a_equal, rsp_bus.a_greater}), "compare flags not one-hot")
   `ASSERT_NEVER(a_dz_only_div, clock, reset, valid_s[DVD_W] && side_s[DVD_W].dz && !side_s[DVD_W].is_div, "zero divisor flag on a non-divide beat")
   `ASSERT_AT(a_stall_hold, clock, reset, (!adv && valid_s[DVD_W]) |=> $stable(side_s[DVD_W]), "last divider stage moved during a stall")

endmodule
